>>> design/pdc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pdc_pkg: shared types and constants of the drop-probability controller
// Item structs, register indexes, field widths and register reset values.
// ----------------------------------------------------------------------------
package pdc_pkg;

  localparam int unsigned DELAY_W = 16;
  localparam int unsigned PROB_W  = 16;
  localparam int unsigned GAIN_W  = 18;
  localparam int unsigned TICK_W  = 16;
  localparam int unsigned BURST_W = 17;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 18;

  localparam logic [CFG_IDX_W-1:0] REG_TARGET_DELAY    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_UPDATE_PERIOD   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_ALPHA_GAIN      = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_BETA_GAIN       = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_PROBABILITY = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_BURST_ALLOWANCE = 3'd5;

  localparam logic [DELAY_W-1:0] TARGET_DELAY_RST    = 16'd15;
  localparam logic [TICK_W-1:0]  UPDATE_PERIOD_RST   = 16'd30;
  localparam logic [GAIN_W-1:0]  ALPHA_GAIN_RST      = 18'd8192;
  localparam logic [GAIN_W-1:0]  BETA_GAIN_RST       = 18'd81920;
  localparam logic [PROB_W-1:0]  MAX_PROBABILITY_RST = 16'd6554;
  localparam logic [DELAY_W-1:0] BURST_ALLOWANCE_RST = 16'd150;

  localparam logic [TICK_W-1:0]  TICK_MAX = {TICK_W{1'b1}};

  localparam logic ACT_ARRIVAL = 1'b0;
  localparam logic ACT_DRAIN   = 1'b1;

  typedef struct packed {
    logic               action;
    logic [DELAY_W-1:0] queue_delay;
    logic [PROB_W-1:0]  random_value;
  } in_item_t;

  typedef struct packed {
    logic              drop;
    logic [PROB_W-1:0] drop_probability;
    logic              updated;
  } out_item_t;

endpackage

>>> design/pie_drop_controller.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pie_drop_controller: drop-probability controller for queue management
// Registered input item, one pass of update and drop logic, registered result.
// ----------------------------------------------------------------------------
// One item per clock cycle, sustained while the output is not stalled. An
// accepted item sits in the input register while the proportional-integral
// update (two 19x17 signed multiplies, a sum and a clamp) and the drop test
// run on it; the result register takes it once the output is free, and the
// controller state moves at that same edge, so the next item sees it at once.
// The result is registered. Configuration writes are always ready and
// must be issued only while no item is in flight.
module pie_drop_controller (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  pdc_pkg::in_item_t             in_item,
  output logic                          out_valid,
  input  logic                          out_stall,
  output pdc_pkg::out_item_t            out_item,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [pdc_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [pdc_pkg::CFG_DATA_W-1:0] cfg_data
);

  logic [pdc_pkg::DELAY_W-1:0] target_delay;
  logic [pdc_pkg::TICK_W-1:0]  update_period;
  logic [pdc_pkg::GAIN_W-1:0]  alpha_gain;
  logic [pdc_pkg::GAIN_W-1:0]  beta_gain;
  logic [pdc_pkg::PROB_W-1:0]  max_probability;
  logic [pdc_pkg::DELAY_W-1:0] burst_allowance;

  logic [pdc_pkg::PROB_W-1:0]  probability, probability_next;
  logic [pdc_pkg::DELAY_W-1:0] previous_delay, previous_delay_next;
  logic [pdc_pkg::TICK_W-1:0]  ticks_since_update, ticks_since_update_next;
  logic [pdc_pkg::BURST_W-1:0] burst_left_time, burst_left_time_next;

  logic               stage_valid;
  pdc_pkg::in_item_t  stage_item;
  pdc_pkg::out_item_t result_next;

  logic out_free;
  logic advance;

  logic               do_update;
  logic signed [16:0] err;
  logic signed [16:0] change;
  logic signed [35:0] alpha_term;
  logic signed [35:0] beta_term;
  logic signed [37:0] sum;
  logic               above_target;

  assign cfg_ready = 1'b1;
  assign out_free  = !out_valid || !out_stall;
  assign advance   = stage_valid && out_free;
  assign in_stall  = stage_valid && !out_free;

  always_ff @(posedge clk) begin
    if (rst) begin
      target_delay    <= pdc_pkg::TARGET_DELAY_RST;
      update_period   <= pdc_pkg::UPDATE_PERIOD_RST;
      alpha_gain      <= pdc_pkg::ALPHA_GAIN_RST;
      beta_gain       <= pdc_pkg::BETA_GAIN_RST;
      max_probability <= pdc_pkg::MAX_PROBABILITY_RST;
      burst_allowance <= pdc_pkg::BURST_ALLOWANCE_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        pdc_pkg::REG_TARGET_DELAY:    target_delay    <= cfg_data[15:0];
        pdc_pkg::REG_UPDATE_PERIOD:   update_period   <= cfg_data[15:0];
        pdc_pkg::REG_ALPHA_GAIN:      alpha_gain      <= cfg_data;
        pdc_pkg::REG_BETA_GAIN:       beta_gain       <= cfg_data;
        pdc_pkg::REG_MAX_PROBABILITY: max_probability <= cfg_data[15:0];
        pdc_pkg::REG_BURST_ALLOWANCE: burst_allowance <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    do_update    = ticks_since_update >= update_period;
    err          = signed'({1'b0, stage_item.queue_delay}) - signed'({1'b0, target_delay});
    change       = signed'({1'b0, stage_item.queue_delay}) - signed'({1'b0, previous_delay});
    alpha_term   = signed'({1'b0, alpha_gain}) * err;
    beta_term    = signed'({1'b0, beta_gain}) * change;
    sum          = signed'({22'd0, probability})
                 + signed'({{2{alpha_term[35]}}, alpha_term})
                 + signed'({{2{beta_term[35]}}, beta_term});
    above_target = stage_item.queue_delay > target_delay;

    probability_next     = probability;
    previous_delay_next  = previous_delay;
    burst_left_time_next = burst_left_time;
    ticks_since_update_next = ticks_since_update;

    if (do_update) begin
      if (sum[37]) begin
        probability_next = '0;
      end else if (sum > signed'({22'd0, max_probability})) begin
        probability_next = max_probability;
      end else begin
        probability_next = sum[15:0];
      end
      previous_delay_next     = stage_item.queue_delay;
      ticks_since_update_next = '0;
      if (above_target) begin
        burst_left_time_next = '0;
      end else if (burst_left_time < {1'b0, burst_allowance}) begin
        burst_left_time_next = burst_left_time + {1'b0, update_period};
      end
    end

    if (ticks_since_update_next != pdc_pkg::TICK_MAX) begin
      ticks_since_update_next = ticks_since_update_next + 1'b1;
    end

    result_next.drop = (stage_item.action == pdc_pkg::ACT_ARRIVAL)
                    && (burst_left_time_next < {1'b0, burst_allowance})
                    && above_target
                    && (stage_item.random_value < probability_next);
    result_next.drop_probability = probability_next;
    result_next.updated          = do_update;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid        <= 1'b0;
      out_valid          <= 1'b0;
      probability        <= '0;
      previous_delay     <= '0;
      ticks_since_update <= '0;
      burst_left_time    <= {1'b0, pdc_pkg::BURST_ALLOWANCE_RST};
    end else begin
      if (!in_stall) begin
        stage_valid <= in_valid;
      end
      if (out_free) begin
        out_valid <= stage_valid;
      end
      if (advance) begin
        probability        <= probability_next;
        previous_delay     <= previous_delay_next;
        ticks_since_update <= ticks_since_update_next;
        burst_left_time    <= burst_left_time_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      stage_item <= in_item;
    end
    if (advance) begin
      out_item <= result_next;
    end
  end

endmodule

>>> design/pdc_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pdc_checker: port-level checks of the drop-probability controller
// Watches handshakes and results over time; bound to the top level.
// ----------------------------------------------------------------------------
module pdc_checker (
  input logic               clk,
  input logic               rst,
  input logic               in_stall,
  input logic               out_valid,
  input logic               out_stall,
  input pdc_pkg::out_item_t out_item
);

  // hold a stalled result
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(out_item))
    else $error("stalled result changed");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result valid after reset");

  a_no_stall_when_empty: assert property (@(posedge clk) disable iff (rst)
    !out_valid |-> !in_stall)
    else $error("input stalled with empty output");

  a_drop_needs_prob: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_item.drop |-> out_item.drop_probability != '0)
    else $error("drop with zero probability");

endmodule

bind pie_drop_controller pdc_checker u_pdc_checker (
  .clk       (clk),
  .rst       (rst),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_item  (out_item)
);
